// ===== hw/rtl/opc_pkg.sv =====
package opc_pkg;

   localparam int XW = 36;
   localparam int ZW = 34;

   localparam logic signed [16:0] QPi     = 17'sd12868;
   localparam logic signed [16:0] QHalfPi = 17'sd6434;
   localparam logic signed [16:0] QTwoPi  = 17'sd25736;
   localparam logic [23:0] InvGainQ24  = 24'd10188014;

   typedef enum logic [1:0] {
      OP_GOAL = 2'd0,
      OP_POSE = 2'd1,
      OP_TICK = 2'd2,
      OP_NONE = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_TURN    = 2'd0,
      MODE_MOVE    = 2'd1,
      MODE_REACHED = 2'd2,
      MODE_RSVD    = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CSR_ROT_GAIN = 3'd0,
      CSR_TRN_GAIN = 3'd1,
      CSR_POS_TOL  = 3'd2,
      CSR_HDG_TOL  = 3'd3,
      CSR_LIN_LIM  = 3'd4,
      CSR_ANG_LIM  = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_SCALE_X,
      ST_SCALE_Y,
      ST_GAIN_X,
      ST_GAIN_Y,
      ST_OUT
   } state_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      case (i)
         5'd0:  return 32'h3243F6A8;
         5'd1:  return 32'h1DAC6705;
         5'd2:  return 32'h0FADBAFC;
         5'd3:  return 32'h07F56EA6;
         5'd4:  return 32'h03FEAB76;
         5'd5:  return 32'h01FFD55B;
         5'd6:  return 32'h00FFFAAA;
         5'd7:  return 32'h007FFF55;
         5'd8:  return 32'h003FFFEA;
         5'd9:  return 32'h001FFFFD;
         5'd10: return 32'h000FFFFF;
         5'd11: return 32'h0007FFFF;
         5'd12: return 32'h0003FFFF;
         5'd13: return 32'h0001FFFF;
         5'd14: return 32'h0000FFFF;
         5'd15: return 32'h00007FFF;
         5'd16: return 32'h00003FFF;
         5'd17: return 32'h00001FFF;
         5'd18: return 32'h00000FFF;
         5'd19: return 32'h000007FF;
         5'd20: return 32'h000003FF;
         5'd21: return 32'h000001FF;
         5'd22: return 32'h000000FF;
         5'd23: return 32'h0000007F;
         default: return 32'h0;
      endcase
   endfunction

endpackage

// ===== hw/rtl/omni_pose_controller.sv =====
// Goal and pose beats give no response. A tick answers through ST_OUT, unless
// it is moving on a fresh pose: then the CORDIC loop and the multiplies come first.
// Throughput: one beat at a time; moving ticks run the CORDIC loop, one rotation
// step per cycle, followed by the states scale X, gain X, scale Y and gain Y.
// Reset (synchronous, active high): pose and target cleared, mode reached,
// registers at their defaults, no result pending.
module omni_pose_controller #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: pos_x[31:0], pos_y[63:32], heading[78:64], zero fill to 80
   input  logic [79:0] req_tdata,
   // tuser: opcode[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: vel_x[15:0], vel_y[31:16], vel_rot[47:32]
   output logic [47:0] rsp_tdata,
   // tuser: mode[1:0]
   output logic [1:0]  rsp_tuser,
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [30:0] csr_wdata
);
   import opc_pkg::*;

   logic [14:0] rot_gain_ff, trn_gain_ff, lin_lim_ff, ang_lim_ff;
   logic [30:0] pos_tol_ff;
   logic [13:0] hdg_tol_ff;

   logic signed [31:0] rx_ff, ry_ff, tx_ff, ty_ff;
   logic signed [14:0] rh_ff, th_ff;
   mode_type mode_ff, mode_in;
   logic pend_ff, pend_in, fresh_ff, fresh_in;

   state_type state_ff, state_in;
   logic [47:0] out_ff, out_in;
   mode_type omode_ff, omode_in;
   logic rvalid_ff, rvalid_in;
   logic signed [XW-1:0] acc_ff, acc_in, cy_ff, cy_in;
   logic signed [15:0] vx_ff, vx_in;

   logic cord_start, cord_done;
   logic signed [XW-1:0] cx0, cy0, cxo, cyo;
   logic signed [ZW-1:0] cz0;

   logic signed [31:0] px, py;
   logic signed [14:0] ph;
   opcode_type op;
   logic acc;

   assign px = req_tdata[31:0];
   assign py = req_tdata[63:32];
   assign ph = req_tdata[78:64];
   assign op = opcode_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE) && !rvalid_ff;
   assign acc = req_tvalid && req_tready;

   // window and box tests on the incoming pose
   logic signed [16:0] lo, hi, z17;
   logic lo_wr, hi_wr, in_win, in_box;
   logic signed [33:0] tol34;
   always_comb begin
      z17 = 17'(ph);
      lo = 17'(th_ff) - 17'(hdg_tol_ff);
      hi = 17'(th_ff) + 17'(hdg_tol_ff);
      lo_wr = 1'b0;
      hi_wr = 1'b0;
      if (lo < -QPi) begin
         lo = lo + QTwoPi;
         lo_wr = 1'b1;
      end else if (hi > QPi) begin
         hi = hi - QTwoPi;
         hi_wr = 1'b1;
      end
      in_win = (z17 > lo && z17 < hi) || ((lo_wr || hi_wr) && (z17 > lo || z17 < hi));
      tol34 = 34'(pos_tol_ff);
      in_box = 34'(px) > 34'(tx_ff) - tol34 && 34'(px) < 34'(tx_ff) + tol34 &&
               34'(py) > 34'(ty_ff) - tol34 && 34'(py) < 34'(ty_ff) + tol34;
   end

   // turning command
   logic signed [16:0] herr;
   logic signed [32:0] rprod;
   logic signed [20:0] rsh;
   logic signed [15:0] vrot;
   always_comb begin
      herr = 17'(th_ff) - 17'(rh_ff);
      if (herr > QPi) herr = herr - QTwoPi;
      else if (herr < -QPi) herr = herr + QTwoPi;
      rprod = 33'(herr) * $signed({1'b0, rot_gain_ff}) + 33'sd2048;
      rsh = 21'(rprod >>> 12);
      if (rsh > $signed({6'd0, ang_lim_ff})) vrot = 16'({1'b0, ang_lim_ff});
      else if (rsh < -$signed({6'd0, ang_lim_ff})) vrot = -16'({1'b0, ang_lim_ff});
      else vrot = 16'(rsh);
   end

   // CORDIC start vector
   logic signed [16:0] ang;
   logic signed [XW-1:0] dx, dy;
   always_comb begin
      dx = XW'(tx_ff) - XW'(rx_ff);
      dy = XW'(ty_ff) - XW'(ry_ff);
      ang = -17'(rh_ff);
      cx0 = dx;
      cy0 = dy;
      if (ang > QHalfPi) begin
         cx0 = -dx; cy0 = -dy; ang = ang - QPi;
      end else if (ang < -QHalfPi) begin
         cx0 = -dx; cy0 = -dy; ang = ang + QPi;
      end
      cz0 = ZW'(ang) <<< 18;
   end

   // multipliers shared by x and y: scale by 1/K, then by gain
   logic signed [XW+25:0] sprod;
   logic signed [XW+16:0] gprod;
   logic signed [XW-1:0] scaled;
   logic signed [XW+1:0] gsh;
   logic signed [15:0] vlin;
   always_comb begin
      sprod = (XW+26)'(state_ff == ST_SCALE_X ? cxo : cy_ff)
              * $signed({2'b0, InvGainQ24}) + (XW+26)'(64'sd1 <<< 23);
      scaled = XW'(sprod >>> 24);
      gprod = (XW+17)'(acc_ff) * $signed({2'b0, trn_gain_ff}) + (XW+17)'(32'sd32768);
      gsh = (XW+2)'(gprod >>> 16);
      if (gsh > $signed({(XW-13)'(0), lin_lim_ff})) vlin = 16'({1'b0, lin_lim_ff});
      else if (gsh < -$signed({(XW-13)'(0), lin_lim_ff})) vlin = -16'({1'b0, lin_lim_ff});
      else vlin = 16'(gsh);
   end

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      pend_in = pend_ff;
      fresh_in = fresh_ff;
      out_in = out_ff;
      omode_in = omode_ff;
      rvalid_in = rvalid_ff;
      acc_in = acc_ff;
      cy_in = cy_ff;
      vx_in = vx_ff;
      cord_start = 1'b0;
      if (rvalid_ff && rsp_tready) rvalid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               case (op)
                  OP_GOAL: begin
                     pend_in = 1'b1;
                     mode_in = MODE_TURN;
                  end
                  OP_POSE: begin
                     fresh_in = 1'b1;
                     if (pend_ff) begin
                        if (in_win) begin
                           mode_in = MODE_MOVE;
                           if (in_box) begin
                              mode_in = MODE_REACHED;
                              pend_in = 1'b0;
                           end
                        end else begin
                           mode_in = MODE_TURN;
                        end
                     end
                  end
                  OP_TICK: begin
                     omode_in = mode_ff;
                     out_in = '0;
                     if (mode_ff != MODE_REACHED && fresh_ff) begin
                        fresh_in = 1'b0;
                        if (mode_ff == MODE_TURN) out_in = {vrot, 32'd0};
                        else if (mode_ff == MODE_MOVE) begin
                           cord_start = 1'b1;
                           state_in = ST_CORDIC;
                        end
                     end
                     if (state_in == ST_IDLE) state_in = ST_OUT;
                  end
                  default: ;
               endcase
            end
         end
         ST_CORDIC: if (cord_done) begin
            cy_in = cyo;
            state_in = ST_SCALE_X;
         end
         ST_SCALE_X: begin
            acc_in = scaled;
            state_in = ST_GAIN_X;
         end
         ST_GAIN_X: begin
            vx_in = vlin;
            state_in = ST_SCALE_Y;
         end
         ST_SCALE_Y: begin
            acc_in = scaled;
            state_in = ST_GAIN_Y;
         end
         ST_GAIN_Y: begin
            out_in = {16'd0, vlin, vx_ff};
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rvalid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   opc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(cord_start),
      .x_start(cx0), .y_start(cy0), .z_start(cz0),
      .done(cord_done), .x_out(cxo), .y_out(cyo)
   );

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      omode_ff <= omode_in;
      acc_ff <= acc_in;
      cy_ff <= cy_in;
      vx_ff <= vx_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         rvalid_ff <= 1'b0;
         mode_ff <= MODE_REACHED;
         pend_ff <= 1'b0;
         fresh_ff <= 1'b0;
         rx_ff <= '0; ry_ff <= '0; rh_ff <= '0;
         tx_ff <= '0; ty_ff <= '0; th_ff <= '0;
         rot_gain_ff <= 15'd1843;
         trn_gain_ff <= 15'd2048;
         pos_tol_ff <= 31'd655;
         hdg_tol_ff <= 14'd41;
         lin_lim_ff <= 15'd328;
         ang_lim_ff <= 15'd3277;
      end else begin
         state_ff <= state_in;
         rvalid_ff <= rvalid_in;
         mode_ff <= mode_in;
         pend_ff <= pend_in;
         fresh_ff <= fresh_in;
         if (acc && op == OP_GOAL) begin
            tx_ff <= px; ty_ff <= py; th_ff <= ph;
         end
         if (acc && op == OP_POSE) begin
            rx_ff <= px; ry_ff <= py; rh_ff <= ph;
         end
         if (csr_wen) begin
            case (csr_index_type'(csr_index))
               CSR_ROT_GAIN: rot_gain_ff <= csr_wdata[14:0];
               CSR_TRN_GAIN: trn_gain_ff <= csr_wdata[14:0];
               CSR_POS_TOL:  pos_tol_ff <= csr_wdata;
               CSR_HDG_TOL:  hdg_tol_ff <= csr_wdata[13:0];
               CSR_LIN_LIM:  lin_lim_ff <= csr_wdata[14:0];
               CSR_ANG_LIM:  ang_lim_ff <= csr_wdata[14:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata = out_ff;
   assign rsp_tuser = omode_ff;
endmodule

// ===== hw/rtl/opc_cordic.sv =====
module opc_cordic #(
   parameter int STEPS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [opc_pkg::XW-1:0] x_start,
   input  logic signed [opc_pkg::XW-1:0] y_start,
   input  logic signed [opc_pkg::ZW-1:0] z_start,
   output logic                         done,
   output logic signed [opc_pkg::XW-1:0] x_out,
   output logic signed [opc_pkg::XW-1:0] y_out
);
   import opc_pkg::*;

   localparam int CW = $clog2(STEPS + 1);

   logic signed [XW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic [CW-1:0] step_ff, step_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic signed [XW-1:0] xs, ys;
   logic signed [ZW-1:0] at;

   always_comb begin
      xs = x_ff >>> step_ff;
      ys = y_ff >>> step_ff;
      at = ZW'(atan_entry(5'(step_ff)));
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in = x_start;
         y_in = y_start;
         z_in = z_start;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == CW'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;
endmodule

// ===== hw/rtl/omni_pose_controller_checker.sv =====
module omni_pose_controller_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   import opc_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_no_accept_when_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken while result pending");

   a_reached_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == MODE_REACHED |-> rsp_tdata == 48'd0)
      else $error("reached mode with nonzero command");

   a_turn_no_lin: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == MODE_TURN |-> rsp_tdata[31:0] == 32'd0)
      else $error("turning mode with linear command");

   a_mode_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != MODE_RSVD)
      else $error("reserved mode code");
endmodule

bind omni_pose_controller omni_pose_controller_checker u_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
);
